### hw/rtl/bqc_pkg.sv
// Shared types, constants and the control store for the biquad cascade unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bqc_pkg;

    localparam int FRAC_BITS = 30;
    localparam logic [63:0] ROUND_CONST = 64'(1) << (FRAC_BITS - 1);
    localparam logic signed [31:0] SAT_HIGH = 32'sd1073709056;
    localparam logic signed [31:0] SAT_LOW = -32'sd1073741824;

    typedef enum logic [1:0] {
        MODE_FIRST   = 2'd0,
        MODE_SAT2    = 2'd1,
        MODE_RAW2    = 2'd2,
        MODE_CASCADE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_FF1  = 3'd1,
        REG_FB1  = 3'd2,
        REG_FF2  = 3'd3,
        REG_FB2  = 3'd4,
        REG_B2   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        OPA_X0 = 3'd0,
        OPA_X1 = 3'd1,
        OPA_X2 = 3'd2,
        OPA_Y1 = 3'd3,
        OPA_Y2 = 3'd4
    } opa_t;

    typedef enum logic [2:0] {
        CO_B0 = 3'd0,
        CO_B1 = 3'd1,
        CO_B2 = 3'd2,
        CO_A1 = 3'd3,
        CO_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT      = 2'd0,
        JMP_IF_FIRST  = 2'd1,
        JMP_IF_SINGLE = 2'd2
    } jump_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_S1_TAIL = 4'd5;
    localparam step_t STEP_EMIT    = 4'd14;

    typedef struct packed {
        logic      mul_en;
        opa_t      opa;
        coef_sel_t coef;
        logic      sec;
        acc_op_t   acc_op;
        logic      finish;
        logic      emit;
        jump_t     jump;
        step_t     target;
    } ucode_t;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic      load;
        logic      mul_en;
        opa_t      opa;
        coef_sel_t coef;
        logic      sec;
        acc_op_t   acc_op;
        logic      finish;
        logic      emit;
    } dp_ctrl_t;

    // Coefficients indexed by section.
    typedef struct packed {
        logic [1:0][31:0] b0;
        logic [1:0][31:0] b1;
        logic [1:0][31:0] b2;
        logic [1:0][31:0] a1;
        logic [1:0][31:0] a2;
    } coef_bank_t;

    function automatic ucode_t mk(logic mul_en, opa_t opa, coef_sel_t coef, logic sec,
                                  acc_op_t acc_op, logic finish, logic emit,
                                  jump_t jump, step_t target);
        ucode_t w;
        w.mul_en = mul_en;
        w.opa    = opa;
        w.coef   = coef;
        w.sec    = sec;
        w.acc_op = acc_op;
        w.finish = finish;
        w.emit   = emit;
        w.jump   = jump;
        w.target = target;
        return w;
    endfunction

    // Steps issue a product, accumulate the one issued the step before, or both; the finish and emit steps do neither.
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w = mk(1'b0, OPA_X0, CO_B0, 1'b0, ACC_HOLD, 1'b0, 1'b1, JMP_NEXT, '0);
        unique case (step)
            4'd0:  w = mk(1'b1, OPA_X0, CO_B0, 1'b0, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd1:  w = mk(1'b1, OPA_X1, CO_B1, 1'b0, ACC_LOAD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd2:  w = mk(1'b1, OPA_Y1, CO_A1, 1'b0, ACC_ADD, 1'b0, 1'b0, JMP_IF_FIRST,
                          STEP_S1_TAIL);
            4'd3:  w = mk(1'b1, OPA_X2, CO_B2, 1'b0, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd4:  w = mk(1'b1, OPA_Y2, CO_A2, 1'b0, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd5:  w = mk(1'b0, OPA_X0, CO_B0, 1'b0, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd6:  w = mk(1'b0, OPA_X0, CO_B0, 1'b0, ACC_HOLD, 1'b1, 1'b0, JMP_IF_SINGLE,
                          STEP_EMIT);
            4'd7:  w = mk(1'b1, OPA_X0, CO_B0, 1'b1, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd8:  w = mk(1'b1, OPA_X1, CO_B1, 1'b1, ACC_LOAD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd9:  w = mk(1'b1, OPA_Y1, CO_A1, 1'b1, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd10: w = mk(1'b1, OPA_X2, CO_B2, 1'b1, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd11: w = mk(1'b1, OPA_Y2, CO_A2, 1'b1, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd12: w = mk(1'b0, OPA_X0, CO_B0, 1'b1, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, '0);
            4'd13: w = mk(1'b0, OPA_X0, CO_B0, 1'b1, ACC_HOLD, 1'b1, 1'b0, JMP_NEXT, '0);
            default: ;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bqc_sequencer.sv
// Step counter and control-store sequencer for the biquad cascade unit.
// Depends on bqc_pkg for the control word layout and the program.
`default_nettype none

module bqc_sequencer
    import bqc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire mode_t    mode,
    output dp_ctrl_t      ctrl
);

    logic   busy_reg, busy_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    ucode_t uw;
    logic   stall;
    logic   accept;

    assign uw       = ucode_rom(step_reg);
    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;
    // The result step waits while the previous result has not been taken.
    assign stall    = uw.emit && out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        if (!busy_reg)
        begin
            ctrl.load = accept;
            if (accept)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (!stall)
        begin
            ctrl.mul_en = uw.mul_en;
            ctrl.opa    = uw.opa;
            ctrl.coef   = uw.coef;
            ctrl.sec    = uw.sec;
            ctrl.acc_op = uw.acc_op;
            ctrl.finish = uw.finish;
            ctrl.emit   = uw.emit;
            if (uw.emit)
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                unique case (uw.jump)
                    JMP_IF_FIRST:
                        step_next = (mode == MODE_FIRST) ? uw.target : step_reg + 4'd1;
                    JMP_IF_SINGLE:
                        step_next = (mode != MODE_CASCADE) ? uw.target : step_reg + 4'd1;
                    default:
                        step_next = step_reg + 4'd1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bqc_datapath.sv
// Shared multiply-accumulate datapath, section histories and result register.
// Depends on bqc_pkg; driven by bqc_sequencer.
`default_nettype none

module bqc_datapath
    import bqc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_ctrl_t    ctrl,
    input  wire logic        hist_clear,
    input  wire mode_t       mode,
    input  wire coef_bank_t  coefs,
    input  wire logic [31:0] sample_in,
    output logic [31:0]      sample_out
);

    logic [31:0]            x_cur_reg;
    logic [1:0][1:0][31:0]  xh_reg;
    logic [1:0][1:0][31:0]  yh_reg;
    logic signed [63:0]     prod_reg;
    logic [63:0]            acc_reg;
    logic [31:0]            out_reg;
    logic [31:0]            opa;
    logic [31:0]            opb;
    logic [63:0]            rounded;
    logic signed [63:0]     shifted;
    logic [31:0]            y0;
    logic signed [31:0]     cur_s;
    logic [31:0]            result;

    always_comb
    begin
        case (ctrl.opa)
            OPA_X1:  opa = xh_reg[ctrl.sec][0];
            OPA_X2:  opa = xh_reg[ctrl.sec][1];
            OPA_Y1:  opa = yh_reg[ctrl.sec][0];
            OPA_Y2:  opa = yh_reg[ctrl.sec][1];
            default: opa = x_cur_reg;
        endcase
        case (ctrl.coef)
            CO_B1:   opb = coefs.b1[ctrl.sec];
            CO_B2:   opb = coefs.b2[ctrl.sec];
            CO_A1:   opb = coefs.a1[ctrl.sec];
            CO_A2:   opb = coefs.a2[ctrl.sec];
            default: opb = coefs.b0[ctrl.sec];
        endcase
    end

    assign rounded = acc_reg + ROUND_CONST;
    assign shifted = $signed(rounded) >>> FRAC_BITS;
    assign y0      = shifted[31:0];

    // Clamping applies to the returned value in every mode but MODE_RAW2.
    assign cur_s = $signed(x_cur_reg);
    always_comb
    begin
        if (mode == MODE_RAW2)
            result = x_cur_reg;
        else if (cur_s > SAT_HIGH)
            result = SAT_HIGH;
        else if (cur_s < SAT_LOW)
            result = SAT_LOW;
        else
            result = x_cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            x_cur_reg <= sample_in;
        else if (ctrl.finish)
            x_cur_reg <= y0;
        if (ctrl.mul_en)
            prod_reg <= $signed(opa) * $signed(opb);
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:  ;
        endcase
        if (ctrl.emit)
            out_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh_reg <= '0;
            yh_reg <= '0;
        end
        else if (hist_clear)
        begin
            xh_reg <= '0;
            yh_reg <= '0;
        end
        else if (ctrl.finish)
        begin
            xh_reg[ctrl.sec][1] <= xh_reg[ctrl.sec][0];
            xh_reg[ctrl.sec][0] <= x_cur_reg;
            yh_reg[ctrl.sec][1] <= yh_reg[ctrl.sec][0];
            yh_reg[ctrl.sec][0] <= y0;
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

### hw/rtl/fixed_point_iir_biquad_cascade_unit.sv
// Top level of the fixed-point biquad cascade: configuration registers and wiring.
// Depends on bqc_pkg, bqc_sequencer and bqc_datapath.
//
//   Channel   Signals                          Direction
//   input     in_valid, in_ready, sample_in    sample transactions into the filter
//   output    out_valid, out_ready, sample_out filtered sample transactions out
//   config    cfg_we, cfg_index, cfg_data      register writes, no wait
//
// One shared 32x32 multiplier runs a microprogram of one step per cycle unless a
// result not yet taken stalls it. First-order mode skips the x2 and y2 terms and
// only the cascade runs section two; no sample is taken until the result is out.
// Reset restores mode 1, zero coefficients and zero histories; any register write
// clears the histories. A result not yet taken holds the sequencer at its last step.
`default_nettype none

module fixed_point_iir_biquad_cascade_unit
    import bqc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] sample_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      sample_out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    mode_t       mode_reg;
    logic [63:0] ff1_reg;
    logic [63:0] fb1_reg;
    logic [63:0] ff2_reg;
    logic [63:0] fb2_reg;
    logic [63:0] b2_reg;
    logic        hist_clear;
    coef_bank_t  coefs;
    dp_ctrl_t    ctrl;

    assign hist_clear = cfg_we && (cfg_index <= REG_B2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SAT2;
            ff1_reg  <= '0;
            fb1_reg  <= '0;
            ff2_reg  <= '0;
            fb2_reg  <= '0;
            b2_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                REG_FF1:  ff1_reg  <= cfg_data;
                REG_FB1:  fb1_reg  <= cfg_data;
                REG_FF2:  ff2_reg  <= cfg_data;
                REG_FB2:  fb2_reg  <= cfg_data;
                REG_B2:   b2_reg   <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        coefs.b0[0] = ff1_reg[31:0];
        coefs.b1[0] = ff1_reg[63:32];
        coefs.a1[0] = fb1_reg[31:0];
        coefs.a2[0] = fb1_reg[63:32];
        coefs.b2[0] = b2_reg[31:0];
        coefs.b0[1] = ff2_reg[31:0];
        coefs.b1[1] = ff2_reg[63:32];
        coefs.a1[1] = fb2_reg[31:0];
        coefs.a2[1] = fb2_reg[63:32];
        coefs.b2[1] = b2_reg[63:32];
    end

    bqc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mode      (mode_reg),
        .ctrl      (ctrl)
    );

    bqc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .hist_clear (hist_clear),
        .mode       (mode_reg),
        .coefs      (coefs),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire
